// ----- hdl/kmle_pkg.sv -----
// Shared constants and types for the key matrix layer event engine.
package kmle_pkg;

   localparam int ROW_COUNT   = 4;
   localparam int COL_COUNT   = 8;
   localparam int LAYER_COUNT = 4;
   localparam int KEY_COUNT   = 32;
   localparam int STORE_DEPTH = 128;
   localparam int ADDR_W      = 7;

   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 16;

   localparam logic [7:0] DEBOUNCE_RESET    = 8'd6;
   localparam logic [7:0] CODE_FLOOR_RESET  = 8'd8;
   localparam logic [7:0] FIRST_ACT_RESET   = 8'd1;
   localparam logic [7:0] STABLE_MAX        = 8'd255;
   localparam logic [7:0] ACTION_COUNT      = 8'd8;

   typedef enum logic [1:0] {
      EV_PRESS       = 2'd0,
      EV_RELEASE     = 2'd1,
      EV_RELEASE_ALL = 2'd2,
      EV_ACTION      = 2'd3
   } ev_kind_type;

   typedef enum logic [2:0] {
      CSR_DEBOUNCE    = 3'd0,
      CSR_LAYER_ONE   = 3'd1,
      CSR_LAYER_TWO   = 3'd2,
      CSR_LAYER_THREE = 3'd3,
      CSR_CODE_FLOOR  = 3'd4,
      CSR_FIRST_ACT   = 3'd5
   } csr_index_type;

   localparam logic [0:0] MODE_LAYOUT = 1'b1;

   typedef struct packed {
      ev_kind_type kind;
      logic [7:0]  code;
      logic [2:0]  action;
   } event_type;

endpackage

// ----- hdl/key_matrix_layer_event_engine.sv -----
// Key matrix debouncer with layered keycode lookup and event emission.
// A layout write or a sample that is not accepted leaves the engine idle. An accepted
// sample walks every key with a store read and then an evaluate step, then a final
// flush step, through the single store read port; no new request is taken until the
// walk is done, and result backpressure stalls the evaluate and flush steps.
// Reset is synchronous: state and CSRs return to defaults; the layout store reads zero.
module key_matrix_layer_event_engine
   import kmle_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // key_bits[31:0], entry_layer[33:32], entry_row[35:34], entry_col[38:36],
   // entry_code[46:39], zero [47]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // key_code[7:0], action[10:8], zero [15:11]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // event_res[1:0]
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FLUSH
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  debounce_ff;
   logic [31:0] layer_one_ff, layer_two_ff, layer_three_ff;
   logic [7:0]  code_floor_ff, first_act_ff;

   logic [31:0] prev_ff, prev_in;
   logic [31:0] accepted_ff, accepted_in;
   logic [31:0] changed_ff, changed_in;
   logic [7:0]  stable_ff, stable_in;
   logic [1:0]  layer_ff, layer_in;
   logic [2:0]  row_ff, row_in;
   logic [2:0]  col_ff, col_in;
   event_type   pend_ff, pend_in;
   logic        pend_valid_ff, pend_valid_in;
   event_type   rsp_ev_ff, rsp_ev_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [7:0]             layout_mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] entry_valid_ff;
   logic [7:0]             mem_rd_ff;
   logic                   mem_rd_valid_ff;

   logic              req_fire, wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [31:0]       sample;
   logic [7:0]        stable_next;
   logic              take;
   logic [1:0]        layer_sel;
   logic              out_free;
   logic [5:0]        key_idx;
   logic              key_ok, key_chg, key_on, last_key;
   logic [7:0]        code, act_diff;
   logic              is_act;
   event_type         cand;
   logic              cand_valid;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign sample     = req_tdata[31:0];
   assign wr_en      = req_fire && (req_tuser == MODE_LAYOUT[0]);
   assign wr_addr    = {req_tdata[33:32], req_tdata[35:34], req_tdata[38:36]};
   assign rd_en      = (state_ff == ST_READ);
   assign rd_addr    = {layer_ff, row_ff[1:0], col_ff};
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ev_ff.action, rsp_ev_ff.code};
   assign rsp_tuser  = rsp_ev_ff.kind;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      if (sample != prev_ff) begin
         stable_next = '0;
      end else if (stable_ff != STABLE_MAX) begin
         stable_next = stable_ff + 8'd1;
      end else begin
         stable_next = stable_ff;
      end
      take = (stable_next > debounce_ff) && (sample != accepted_ff);
      if ((sample & layer_one_ff) != '0) begin
         layer_sel = 2'd1;
      end else if ((sample & layer_two_ff) != '0) begin
         layer_sel = 2'd2;
      end else if ((sample & layer_three_ff) != '0) begin
         layer_sel = 2'd3;
      end else begin
         layer_sel = 2'd0;
      end
   end

   always_comb begin
      key_idx  = 6'(row_ff) * 6'(COL_COUNT) + 6'(col_ff);
      key_ok   = key_idx < 6'(KEY_COUNT);
      key_chg  = key_ok && changed_ff[key_idx[4:0]];
      key_on   = accepted_ff[key_idx[4:0]];
      last_key = (row_ff == 3'(ROW_COUNT - 1)) && (col_ff == 3'(COL_COUNT - 1));
      code     = mem_rd_valid_ff ? mem_rd_ff : 8'd0;
      act_diff = code - first_act_ff;
      is_act   = (code >= first_act_ff) && (act_diff < ACTION_COUNT);
      cand       = '{kind: EV_PRESS, code: 8'd0, action: 3'd0};
      cand_valid = 1'b0;
      if (key_chg) begin
         if (key_on) begin
            if (is_act) begin
               cand       = '{kind: EV_ACTION, code: 8'd0, action: act_diff[2:0]};
               cand_valid = 1'b1;
            end else if (code > code_floor_ff) begin
               cand       = '{kind: EV_PRESS, code: code, action: 3'd0};
               cand_valid = 1'b1;
            end
         end else if (code > code_floor_ff) begin
            cand       = '{kind: EV_RELEASE, code: code, action: 3'd0};
            cand_valid = 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      prev_in       = prev_ff;
      accepted_in   = accepted_ff;
      changed_in    = changed_ff;
      stable_in     = stable_ff;
      layer_in      = layer_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser != MODE_LAYOUT[0])) begin
               prev_in   = sample;
               stable_in = stable_next;
               if (take) begin
                  accepted_in = sample;
                  changed_in  = sample ^ accepted_ff;
                  row_in      = '0;
                  col_in      = '0;
                  state_in    = ST_READ;
                  if (layer_sel != layer_ff) begin
                     pend_in       = '{kind: EV_RELEASE_ALL, code: 8'd0, action: 3'd0};
                     pend_valid_in = 1'b1;
                     layer_in      = layer_sel;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!(cand_valid && pend_valid_ff && !out_free)) begin
               if (cand_valid) begin
                  if (pend_valid_ff) begin
                     rsp_ev_in    = pend_ff;
                     rsp_last_in  = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  pend_in       = cand;
                  pend_valid_in = 1'b1;
               end
               if (last_key) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_READ;
                  if (col_ff == 3'(COL_COUNT - 1)) begin
                     col_in = '0;
                     row_in = row_ff + 3'd1;
                  end else begin
                     col_in = col_ff + 3'd1;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_ev_in     = pend_ff;
               rsp_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         prev_ff        <= '0;
         accepted_ff    <= '0;
         stable_ff      <= '0;
         layer_ff       <= '0;
         row_ff         <= '0;
         col_ff         <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         debounce_ff    <= DEBOUNCE_RESET;
         layer_one_ff   <= '0;
         layer_two_ff   <= '0;
         layer_three_ff <= '0;
         code_floor_ff  <= CODE_FLOOR_RESET;
         first_act_ff   <= FIRST_ACT_RESET;
      end else begin
         state_ff      <= state_in;
         prev_ff       <= prev_in;
         accepted_ff   <= accepted_in;
         stable_ff     <= stable_in;
         layer_ff      <= layer_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DEBOUNCE:    debounce_ff    <= csr_wdata[7:0];
               CSR_LAYER_ONE:   layer_one_ff   <= csr_wdata;
               CSR_LAYER_TWO:   layer_two_ff   <= csr_wdata;
               CSR_LAYER_THREE: layer_three_ff <= csr_wdata;
               CSR_CODE_FLOOR:  code_floor_ff  <= csr_wdata[7:0];
               CSR_FIRST_ACT:   first_act_ff   <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      changed_ff  <= changed_in;
      pend_ff     <= pend_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (wr_en) begin
         entry_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         layout_mem[wr_addr] <= req_tdata[46:39];
      end
      if (rd_en) begin
         mem_rd_ff       <= layout_mem[rd_addr];
         mem_rd_valid_ff <= entry_valid_ff[rd_addr];
      end
   end

endmodule
